[src/jsm_pkg.sv]
// Shared types, constants and step decoding for the JTAG scan master.
// Used by the sequencer, the output buffer and the top level; no dependencies.
package jsm_pkg;

  localparam int MAX_SHIFT = 64;
  localparam int ID_BITS   = 32;
  localparam int DATA_W    = 64;
  localparam int LEN_W     = 7;
  localparam int STEP_W    = 7;
  localparam int TOTAL_W   = 8;
  localparam int BIT_W     = 6;
  localparam int DIV_W     = 8;
  localparam int REQ_W     = 3;

  localparam logic [3:0] IDCODE_IR = 4'hE;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_TICK     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_RESET    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_IDLE     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SHIFT_IR = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DR_CAP   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DR_NOCAP = 3'd5;
  localparam logic [REQ_W-1:0] REQ_READ_ID  = 3'd6;

  // One input transaction.
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [DATA_W-1:0] shift_data;
    logic [LEN_W-1:0]  shift_length;
    logic              tdo_level;
  } jsm_req_t;

  // One result transaction.
  typedef struct packed {
    logic              tck_level;
    logic              tms_level;
    logic              tdi_level;
    logic              busy_res;
    logic              done_res;
    logic              rejected;
    logic [DATA_W-1:0] captured_data;
  } jsm_res_t;

  // Pin levels and data-bit role of one TCK clock.
  typedef struct packed {
    logic             tms;
    logic             tdi;
    logic             cap;
    logic             dat;
    logic [BIT_W-1:0] bit_sel;
  } jsm_step_t;

  // Total for a command sequence; it ends once the step counter plus one reaches it.
  function automatic logic [TOTAL_W-1:0] seq_total(input logic [REQ_W-1:0] cmd,
                                                   input logic [LEN_W-1:0] n);
    logic [TOTAL_W-1:0] n8;
    logic [TOTAL_W-1:0] tot;
    n8  = {1'b0, n};
    tot = '0;
    unique case (cmd)
      REQ_RESET:                tot = TOTAL_W'(6);
      REQ_IDLE:                 tot = TOTAL_W'(9);
      REQ_SHIFT_IR:             tot = n8 + TOTAL_W'(6);
      REQ_DR_CAP, REQ_DR_NOCAP: tot = n8 + TOTAL_W'(5);
      REQ_READ_ID:              tot = TOTAL_W'(22 + ID_BITS + 4);
      default:                  tot = '0;
    endcase
    return tot;
  endfunction

  // Levels for clock k of the current command.
  function automatic jsm_step_t describe(input logic [REQ_W-1:0]  cmd,
                                         input logic [STEP_W-1:0] k,
                                         input logic [LEN_W-1:0]  n,
                                         input logic [DATA_W-1:0] shift);
    jsm_step_t s;
    logic [TOTAL_W-1:0] k8;
    logic [TOTAL_W-1:0] n8;
    logic [TOTAL_W-1:0] off;
    k8  = {1'b0, k};
    n8  = {1'b0, n};
    off = '0;
    s   = '{tms: 1'b1, tdi: 1'b1, cap: 1'b0, dat: 1'b0, bit_sel: '0};
    unique case (cmd)
      REQ_IDLE: begin
        s.tms = (k8 < TOTAL_W'(6));
      end
      REQ_SHIFT_IR: begin
        if (k8 < TOTAL_W'(4)) begin
          s.tms = (k8 < TOTAL_W'(2));
        end else if (k8 < n8 + TOTAL_W'(4)) begin
          off       = k8 - TOTAL_W'(4);
          s.bit_sel = off[BIT_W-1:0];
          s.tdi     = shift[s.bit_sel];
          s.tms     = (k8 == n8 + TOTAL_W'(3));
          s.dat     = 1'b1;
        end else begin
          s.tms = (k8 == n8 + TOTAL_W'(4));
        end
      end
      REQ_DR_CAP, REQ_DR_NOCAP: begin
        if (k8 < TOTAL_W'(3)) begin
          s.tms = (k8 == '0);
        end else if (k8 < n8 + TOTAL_W'(3)) begin
          off       = k8 - TOTAL_W'(3);
          s.bit_sel = off[BIT_W-1:0];
          s.tdi     = shift[s.bit_sel];
          s.tms     = (k8 == n8 + TOTAL_W'(2));
          s.cap     = (cmd == REQ_DR_CAP);
          s.dat     = 1'b1;
        end else begin
          s.tms = (k8 == n8 + TOTAL_W'(3));
        end
      end
      REQ_READ_ID: begin
        if (k8 < TOTAL_W'(6)) begin
          s.tms = 1'b1;
        end else if (k8 < TOTAL_W'(10)) begin
          s.tms = 1'b0;
        end else if (k8 < TOTAL_W'(12)) begin
          s.tms = 1'b1;
        end else if (k8 < TOTAL_W'(14)) begin
          s.tms = 1'b0;
        end else if (k8 < TOTAL_W'(18)) begin
          off   = k8 - TOTAL_W'(14);
          s.tdi = IDCODE_IR[off[1:0]];
          s.tms = (k8 == TOTAL_W'(17));
        end else if (k8 < TOTAL_W'(20)) begin
          s.tms = 1'b1;
        end else if (k8 < TOTAL_W'(22)) begin
          s.tms = 1'b0;
        end else if (k8 < TOTAL_W'(22 + ID_BITS)) begin
          off       = k8 - TOTAL_W'(22);
          s.bit_sel = off[BIT_W-1:0];
          s.cap     = 1'b1;
          s.dat     = 1'b1;
          s.tms     = (k8 == TOTAL_W'(21 + ID_BITS));
        end else begin
          s.tms = (k8 == TOTAL_W'(22 + ID_BITS));
        end
      end
      default: begin
        s.tms = 1'b1;
      end
    endcase
    return s;
  endfunction

endpackage

[src/jsm_seq.sv]
// Command sequencer of the JTAG scan master: pin state, step counter and
// TDO capture. Depends on jsm_pkg; the result is combinational from state and item.
module jsm_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [jsm_pkg::DIV_W-1:0]   cfg_wdata,
  input  logic                        item_accept,
  input  jsm_pkg::jsm_req_t           item,
  output jsm_pkg::jsm_res_t           res
);
  import jsm_pkg::*;

  logic [DIV_W-1:0]  half_r;
  logic [REQ_W-1:0]  cmd_r, cmd_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DATA_W-1:0] shift_r, shift_nxt;
  logic [DATA_W-1:0] cap_r, cap_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic              tck_r, tck_nxt;
  logic              tms_r, tms_nxt;
  logic              tdi_r, tdi_nxt;
  logic              busy_r, busy_nxt;
  logic              done;
  logic              rej;

  logic [DIV_W-1:0]   hp;
  logic [DIV_W:0]     cnt;
  logic [LEN_W-1:0]   len_sat;
  logic [STEP_W-1:0]  step_inc;
  logic [TOTAL_W-1:0] total;
  jsm_step_t          cur;
  jsm_step_t          nxt;

  // Decode of the current and the following clock.
  assign step_inc = step_r + STEP_W'(1);
  assign cur      = describe(cmd_r, step_r, len_r, shift_r);
  assign nxt      = describe(cmd_r, step_inc, len_r, shift_r);
  assign total    = seq_total(cmd_r, len_r);
  assign hp       = (half_r == '0) ? DIV_W'(1) : half_r;
  assign cnt      = {1'b0, div_r} + (DIV_W+1)'(1);

  // Shift length clamped into 1 .. MAX_SHIFT.
  always_comb begin
    len_sat = item.shift_length;
    if (len_sat == '0) begin
      len_sat = LEN_W'(1);
    end else if (len_sat > LEN_W'(MAX_SHIFT)) begin
      len_sat = LEN_W'(MAX_SHIFT);
    end
  end

  // Next state for one transaction.
  always_comb begin
    cmd_nxt   = cmd_r;
    step_nxt  = step_r;
    shift_nxt = shift_r;
    cap_nxt   = cap_r;
    len_nxt   = len_r;
    div_nxt   = div_r;
    tck_nxt   = tck_r;
    tms_nxt   = tms_r;
    tdi_nxt   = tdi_r;
    busy_nxt  = busy_r;
    done      = 1'b0;
    rej       = 1'b0;
    priority if (item.req_type >= REQ_RESET && item.req_type <= REQ_READ_ID) begin
      if (busy_r) begin
        rej = 1'b1;
      end else begin
        // Every sequence opens with TMS and TDI high.
        cmd_nxt   = item.req_type;
        len_nxt   = len_sat;
        shift_nxt = item.shift_data;
        cap_nxt   = '0;
        step_nxt  = '0;
        div_nxt   = '0;
        busy_nxt  = 1'b1;
        tck_nxt   = 1'b0;
        tms_nxt   = 1'b1;
        tdi_nxt   = 1'b1;
      end
    end else if (item.req_type == REQ_TICK && busy_r) begin
      if (cnt < {1'b0, hp}) begin
        div_nxt = cnt[DIV_W-1:0];
      end else begin
        div_nxt = '0;
        if (!tck_r) begin
          tck_nxt = 1'b1;
        end else begin
          // End of a high half: sample TDO, then advance or finish.
          if (cur.cap && item.tdo_level) begin
            cap_nxt[cur.bit_sel] = 1'b1;
          end
          if ({1'b0, step_r} + TOTAL_W'(1) >= total) begin
            busy_nxt = 1'b0;
            done     = 1'b1;
          end else begin
            step_nxt = step_inc;
            tck_nxt  = 1'b0;
            tms_nxt  = nxt.tms;
            tdi_nxt  = nxt.tdi;
          end
        end
      end
    end else begin
      // Idle tick or unused code: nothing moves.
      busy_nxt = busy_r;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= DIV_W'(1);
      cmd_r   <= '0;
      step_r  <= '0;
      shift_r <= '0;
      cap_r   <= '0;
      len_r   <= '0;
      div_r   <= '0;
      tck_r   <= 1'b0;
      tms_r   <= 1'b1;
      tdi_r   <= 1'b1;
      busy_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        half_r <= cfg_wdata;
      end
      if (item_accept) begin
        cmd_r   <= cmd_nxt;
        step_r  <= step_nxt;
        shift_r <= shift_nxt;
        cap_r   <= cap_nxt;
        len_r   <= len_nxt;
        div_r   <= div_nxt;
        tck_r   <= tck_nxt;
        tms_r   <= tms_nxt;
        tdi_r   <= tdi_nxt;
        busy_r  <= busy_nxt;
      end
    end
  end

  // Result of this transaction.
  assign res.tck_level     = tck_nxt;
  assign res.tms_level     = tms_nxt;
  assign res.tdi_level     = tdi_nxt;
  assign res.busy_res      = busy_nxt;
  assign res.done_res      = done;
  assign res.rejected      = rej;
  assign res.captured_data = cap_nxt;

endmodule

[src/jsm_obuf.sv]
// Two-entry result buffer (output register plus skid stage).
// Depends on jsm_pkg for the result type.
module jsm_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  input  jsm_pkg::jsm_res_t wr_res,
  output logic              wr_ready,
  output logic              rd_valid,
  output jsm_pkg::jsm_res_t rd_res,
  input  logic              rd_ready
);
  import jsm_pkg::*;

  logic     main_vld_r, main_vld_nxt;
  logic     skid_vld_r, skid_vld_nxt;
  jsm_res_t main_r, main_nxt;
  jsm_res_t skid_r, skid_nxt;
  logic     wr_go;
  logic     rd_go;

  assign wr_ready = !skid_vld_r;
  assign wr_go    = wr_valid && wr_ready;
  assign rd_go    = main_vld_r && rd_ready;

  // Keep order: the skid entry always drains into the main entry first.
  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (rd_go) begin
      if (skid_vld_r) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end else if (wr_go) begin
        main_nxt = wr_res;
      end else begin
        main_vld_nxt = 1'b0;
      end
    end else if (wr_go) begin
      if (main_vld_r) begin
        skid_nxt     = wr_res;
        skid_vld_nxt = 1'b1;
      end else begin
        main_nxt     = wr_res;
        main_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign rd_valid = main_vld_r;
  assign rd_res   = main_r;

endmodule

[src/jtag_scan_master.sv]
// Top level of the JTAG scan master: stream ports, sequencer and result buffer.
// Depends on jsm_pkg, jsm_seq and jsm_obuf.

// Every input transaction (command or tick) yields exactly one result
// transaction. The result is registered in the result buffer before it is
// offered, and it waits longer when earlier results still wait at the output.
// A new transaction can be accepted in every cycle while in_tready is high.
// The sequencer's next-state logic is combinational, and a two-entry result
// buffer lets in_tready stay high while one result waits; in_tready falls
// only when two results wait unread. Commands sent while a sequence runs
// come back with the rejected flag.
module jtag_scan_master (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,   // half_period_ticks
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,    // shift_data[63:0], shift_length[70:64], tdo_level[71]
  input  logic [2:0]  in_tuser,    // req_type[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,   // tck[0], tms[1], tdi[2], busy[3], captured[67:4], zero
  output logic        out_tlast,   // done_res
  output logic        out_tuser    // rejected
);
  import jsm_pkg::*;

  jsm_req_t req;
  jsm_res_t res;
  jsm_res_t out_res;
  logic     in_go;

  assign req.req_type     = in_tuser;
  assign req.shift_data   = in_tdata[63:0];
  assign req.shift_length = in_tdata[70:64];
  assign req.tdo_level    = in_tdata[71];
  assign in_go            = in_tvalid && in_tready;

  jsm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .item_accept (in_go),
    .item        (req),
    .res         (res)
  );

  jsm_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_tvalid),
    .wr_res   (res),
    .wr_ready (in_tready),
    .rd_valid (out_tvalid),
    .rd_res   (out_res),
    .rd_ready (out_tready)
  );

  // Pack the result transaction.
  assign out_tdata = {4'b0000, out_res.captured_data, out_res.busy_res,
                      out_res.tdi_level, out_res.tms_level, out_res.tck_level};
  assign out_tlast = out_res.done_res;
  assign out_tuser = out_res.rejected;

  // A finished command is never still busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tdata[3])
    else $error("done result reports busy");

  // A transaction cannot both finish a command and be rejected.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tlast && out_tuser))
    else $error("result both done and rejected");

  // Back-pressure appears only with a result waiting at the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  // A rejected command leaves the busy state unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_go && in_tuser != REQ_TICK && res.rejected |-> res.busy_res)
    else $error("rejected command cleared busy");

endmodule
